// ===== design/jomsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jomsc_pkg
// Shared types and constants for the JSON object member scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jomsc_pkg;

   localparam int DEPTH_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] ASCII_LBRACE  = 8'h7B;
   localparam logic [7:0] ASCII_RBRACE  = 8'h7D;
   localparam logic [7:0] ASCII_LBRACK  = 8'h5B;
   localparam logic [7:0] ASCII_RBRACK  = 8'h5D;
   localparam logic [7:0] ASCII_QUOTE   = 8'h22;
   localparam logic [7:0] ASCII_COMMA   = 8'h2C;
   localparam logic [7:0] ASCII_COLON   = 8'h3A;
   localparam logic [7:0] ASCII_BSLASH  = 8'h5C;
   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_TAB     = 8'h09;
   localparam logic [7:0] ASCII_LF      = 8'h0A;
   localparam logic [7:0] ASCII_CR      = 8'h0D;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_OBJECT   = 3'd1;
   localparam logic [2:0] STATUS_BAD_VALUE    = 3'd2;
   localparam logic [2:0] STATUS_BAD_KEY      = 3'd3;
   localparam logic [2:0] STATUS_TRAIL_COMMA  = 3'd4;
   localparam logic [2:0] STATUS_UNBALANCED   = 3'd5;

   localparam logic KIND_MEMBER = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [3:0] {
      CH_LBRACE,
      CH_RBRACE,
      CH_LBRACK,
      CH_RBRACK,
      CH_QUOTE,
      CH_COMMA,
      CH_COLON,
      CH_BSLASH,
      CH_BLANK,
      CH_OTHER
   } char_class_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_final;
   } req_payload_type;

   typedef struct packed {
      logic                  kind;
      logic [FIELD_BITS-1:0] key_begin;
      logic [FIELD_BITS-1:0] key_stop;
      logic [FIELD_BITS-1:0] value_begin;
      logic [FIELD_BITS-1:0] value_stop;
      logic [2:0]            status;
      logic                  last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      char_class_type char_class;
      logic           is_final;
   } class_item_type;

endpackage

`default_nettype wire

// ===== design/jomsc_front.sv =====
// ----------------------------------------------------------------------------
// jomsc_front
// Accepts characters and registers each one as a character class item.
// ----------------------------------------------------------------------------
`default_nettype none

module jomsc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire jomsc_pkg::req_payload_type req_payload,
   output logic                           item_valid,
   input  wire logic                      item_ready,
   output jomsc_pkg::class_item_type      item
);

   logic                      valid_ff;
   logic                      valid_in;
   jomsc_pkg::class_item_type item_ff;
   jomsc_pkg::class_item_type item_in;
   jomsc_pkg::char_class_type cls;

   always_comb begin
      case (req_payload.char_byte)
         jomsc_pkg::ASCII_LBRACE: cls = jomsc_pkg::CH_LBRACE;
         jomsc_pkg::ASCII_RBRACE: cls = jomsc_pkg::CH_RBRACE;
         jomsc_pkg::ASCII_LBRACK: cls = jomsc_pkg::CH_LBRACK;
         jomsc_pkg::ASCII_RBRACK: cls = jomsc_pkg::CH_RBRACK;
         jomsc_pkg::ASCII_QUOTE:  cls = jomsc_pkg::CH_QUOTE;
         jomsc_pkg::ASCII_COMMA:  cls = jomsc_pkg::CH_COMMA;
         jomsc_pkg::ASCII_COLON:  cls = jomsc_pkg::CH_COLON;
         jomsc_pkg::ASCII_BSLASH: cls = jomsc_pkg::CH_BSLASH;
         jomsc_pkg::ASCII_SPACE,
         jomsc_pkg::ASCII_TAB,
         jomsc_pkg::ASCII_LF,
         jomsc_pkg::ASCII_CR:     cls = jomsc_pkg::CH_BLANK;
         default:                 cls = jomsc_pkg::CH_OTHER;
      endcase
   end

   assign req_ready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in.char_class = cls;
         item_in.is_final   = req_payload.is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== design/jomsc_queue.sv =====
// ----------------------------------------------------------------------------
// jomsc_queue
// Small FIFO of classified items between the front and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module jomsc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire jomsc_pkg::class_item_type in_item,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output jomsc_pkg::class_item_type      out_item
);

   localparam int PB = jomsc_pkg::QUEUE_PTR_BITS;

   jomsc_pkg::class_item_type mem_ff [jomsc_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff;
   logic [PB-1:0] wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff;
   logic [PB-1:0] rd_ptr_in;
   logic [PB:0]   count_ff;
   logic [PB:0]   count_in;
   logic          push;
   logic          pop;

   assign in_ready  = count_ff != (PB+1)'(jomsc_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/jomsc_back.sv =====
// ----------------------------------------------------------------------------
// jomsc_back
// Scanner state and a two-entry result buffer; takes one item per cycle
// when the buffer has room for every result that item makes.
// ----------------------------------------------------------------------------
`default_nettype none

module jomsc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      item_valid,
   output logic                           item_ready,
   input  wire jomsc_pkg::class_item_type item,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output jomsc_pkg::rsp_payload_type     rsp_payload
);

   // offsets wrap at the result field width
   localparam int OFFSET_BITS = jomsc_pkg::FIELD_BITS;
   localparam int DB = jomsc_pkg::DEPTH_BITS;
   localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);
   localparam logic [DB-1:0] DEPTH_ONE = DB'(1);

   // scanner state
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] ko_at_ff, ko_at_in;
   logic [OFFSET_BITS-1:0] kc_at_ff, kc_at_in;
   logic [OFFSET_BITS-1:0] vo_at_ff, vo_at_in;
   logic [DB-1:0]          brace_ff, brace_in;
   logic [DB-1:0]          brack_ff, brack_in;
   logic                   in_str_ff, in_str_in;
   logic                   await_ff, await_in;
   logic                   comma_ff, comma_in;
   logic                   first_bad_ff, first_bad_in;
   logic [2:0]             err_ff, err_in;
   logic                   started_ff, started_in;
   logic                   ko_ff, ko_in;
   logic                   kc_ff, kc_in;
   logic                   vo_ff, vo_in;
   logic                   prev_bs_ff, prev_bs_in;

   // result buffer
   jomsc_pkg::rsp_payload_type ent_ff [2];
   jomsc_pkg::rsp_payload_type ent_in [2];
   logic [1:0]                 cnt_ff, cnt_in;

   logic                       guarded;
   logic                       blank;
   logic                       emit;
   logic                       fin;
   logic [OFFSET_BITS-1:0]     gap;
   logic [2:0]                 status;
   logic [1:0]                 n_res;
   logic [1:0]                 cnt_p;
   logic [1:0]                 free;
   logic                       pop;
   jomsc_pkg::rsp_payload_type member_r;
   jomsc_pkg::rsp_payload_type status_r;

   assign fin     = item.is_final;
   assign blank   = item.char_class == jomsc_pkg::CH_BLANK;
   assign guarded = (brack_ff != '0) || in_str_ff || (brace_ff > DEPTH_ONE);
   assign gap     = pos_ff - vo_at_ff;

   // next scanner state for the item at the queue head
   always_comb begin
      pos_in       = pos_ff + OFF_ONE;
      ko_at_in     = ko_at_ff;
      kc_at_in     = kc_at_ff;
      vo_at_in     = vo_at_ff;
      brace_in     = brace_ff;
      brack_in     = brack_ff;
      in_str_in    = in_str_ff;
      await_in     = await_ff;
      comma_in     = comma_ff;
      first_bad_in = first_bad_ff;
      err_in       = err_ff;
      started_in   = started_ff;
      ko_in        = ko_ff;
      kc_in        = kc_ff;
      vo_in        = vo_ff;
      prev_bs_in   = item.char_class == jomsc_pkg::CH_BSLASH;
      emit         = 1'b0;
      if (!started_ff) begin
         // first character is only checked for an opening brace
         started_in   = 1'b1;
         first_bad_in = item.char_class != jomsc_pkg::CH_LBRACE;
      end else if (!first_bad_ff && err_ff == jomsc_pkg::STATUS_OK) begin
         case (item.char_class)
            jomsc_pkg::CH_LBRACK: begin
               brack_in = brack_ff + DEPTH_ONE;
            end
            jomsc_pkg::CH_RBRACK: begin
               brack_in = brack_ff - DEPTH_ONE;
            end
            jomsc_pkg::CH_LBRACE: begin
               brace_in = brace_ff + DEPTH_ONE;
            end
            jomsc_pkg::CH_QUOTE: begin
               if (prev_bs_ff) begin
                  // escaped quote
               end else if (!ko_ff) begin
                  ko_at_in  = pos_ff + OFF_ONE;
                  ko_in     = 1'b1;
                  kc_in     = 1'b0;
                  in_str_in = 1'b1;
               end else if (!kc_ff) begin
                  kc_at_in  = pos_ff;
                  kc_in     = 1'b1;
                  in_str_in = 1'b0;
               end else begin
                  in_str_in = !in_str_ff;
               end
            end
            jomsc_pkg::CH_RBRACE: begin
               brace_in = brace_ff - DEPTH_ONE;
               if (!guarded) begin
                  if (ko_ff && kc_ff && !vo_ff) begin
                     err_in = jomsc_pkg::STATUS_BAD_VALUE;
                  end else if (vo_ff && vo_at_ff == pos_ff) begin
                     err_in = jomsc_pkg::STATUS_BAD_VALUE;
                  end else if (ko_ff && kc_ff && vo_ff) begin
                     emit     = 1'b1;
                     ko_in    = 1'b0;
                     kc_in    = 1'b0;
                     vo_in    = 1'b0;
                     await_in = 1'b0;
                     comma_in = 1'b0;
                  end else if (comma_ff) begin
                     err_in = jomsc_pkg::STATUS_TRAIL_COMMA;
                  end
               end
            end
            jomsc_pkg::CH_COMMA: begin
               if (!guarded) begin
                  if (!vo_ff) begin
                     err_in = jomsc_pkg::STATUS_BAD_VALUE;
                  end else begin
                     if (ko_ff && kc_ff) begin
                        emit     = 1'b1;
                        ko_in    = 1'b0;
                        kc_in    = 1'b0;
                        vo_in    = 1'b0;
                        await_in = 1'b0;
                     end
                     comma_in = 1'b1;
                  end
               end
            end
            jomsc_pkg::CH_COLON: begin
               if (!guarded) begin
                  if (vo_ff) begin
                     err_in = jomsc_pkg::STATUS_BAD_OBJECT;
                  end else if (!(ko_ff && kc_ff)) begin
                     err_in = jomsc_pkg::STATUS_BAD_KEY;
                  end else begin
                     vo_at_in = pos_ff + OFF_ONE;
                     vo_in    = 1'b1;
                     await_in = 1'b1;
                  end
               end
            end
            default: begin
               if (!ko_ff && !blank) begin
                  err_in = jomsc_pkg::STATUS_BAD_KEY;
               end else if (ko_ff && kc_ff && !blank && !vo_ff) begin
                  err_in = jomsc_pkg::STATUS_BAD_OBJECT;
               end else if (vo_ff && await_ff) begin
                  if (blank && !guarded) begin
                     // skip blanks right after the colon
                     if (gap <= OFF_ONE) begin
                        vo_at_in = pos_ff + OFF_ONE;
                     end
                  end else begin
                     await_in = 1'b0;
                  end
               end
            end
         endcase
      end

      if (first_bad_in || item.char_class != jomsc_pkg::CH_RBRACE) begin
         status = jomsc_pkg::STATUS_BAD_OBJECT;
      end else if (err_in != jomsc_pkg::STATUS_OK) begin
         status = err_in;
      end else if (brack_in != '0 || brace_in != '0 || in_str_in) begin
         status = jomsc_pkg::STATUS_UNBALANCED;
      end else begin
         status = jomsc_pkg::STATUS_OK;
      end

      if (fin) begin
         // back to the reset state for the next document, but for the backslash flag
         pos_in       = '0;
         brace_in     = DEPTH_ONE;
         brack_in     = '0;
         in_str_in    = 1'b0;
         await_in     = 1'b0;
         comma_in     = 1'b0;
         first_bad_in = 1'b0;
         err_in       = jomsc_pkg::STATUS_OK;
         started_in   = 1'b0;
         ko_in        = 1'b0;
         kc_in        = 1'b0;
         vo_in        = 1'b0;
      end
   end

   always_comb begin
      member_r.kind        = jomsc_pkg::KIND_MEMBER;
      member_r.key_begin   = ko_at_ff;
      member_r.key_stop    = kc_at_ff;
      member_r.value_begin = vo_at_ff;
      member_r.value_stop  = pos_ff;
      member_r.status      = jomsc_pkg::STATUS_OK;
      member_r.last_of_run = !fin;

      status_r.kind        = jomsc_pkg::KIND_STATUS;
      status_r.key_begin   = '0;
      status_r.key_stop    = '0;
      status_r.value_begin = '0;
      status_r.value_stop  = '0;
      status_r.status      = status;
      status_r.last_of_run = 1'b1;
   end

   assign n_res      = 2'(emit) + 2'(fin);
   assign rsp_valid  = cnt_ff != 2'd0;
   assign rsp_payload = ent_ff[0];
   assign pop        = rsp_valid && rsp_ready;
   assign cnt_p      = pop ? cnt_ff - 2'd1 : cnt_ff;
   assign free       = 2'd2 - cnt_p;
   assign item_ready = n_res <= free;

   always_comb begin
      ent_in[0] = pop ? ent_ff[1] : ent_ff[0];
      ent_in[1] = ent_ff[1];
      cnt_in    = cnt_p;
      if (item_valid && item_ready) begin
         cnt_in = cnt_p + n_res;
         if (n_res == 2'd2) begin
            ent_in[0] = member_r;
            ent_in[1] = status_r;
         end else if (n_res == 2'd1) begin
            ent_in[cnt_p[0]] = emit ? member_r : status_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         brace_ff     <= DEPTH_ONE;
         brack_ff     <= '0;
         in_str_ff    <= 1'b0;
         await_ff     <= 1'b0;
         comma_ff     <= 1'b0;
         first_bad_ff <= 1'b0;
         err_ff       <= jomsc_pkg::STATUS_OK;
         started_ff   <= 1'b0;
         ko_ff        <= 1'b0;
         kc_ff        <= 1'b0;
         vo_ff        <= 1'b0;
         prev_bs_ff   <= 1'b0;
         cnt_ff       <= 2'd0;
      end else begin
         if (item_valid && item_ready) begin
            pos_ff       <= pos_in;
            brace_ff     <= brace_in;
            brack_ff     <= brack_in;
            in_str_ff    <= in_str_in;
            await_ff     <= await_in;
            comma_ff     <= comma_in;
            first_bad_ff <= first_bad_in;
            err_ff       <= err_in;
            started_ff   <= started_in;
            ko_ff        <= ko_in;
            kc_ff        <= kc_in;
            vo_ff        <= vo_in;
            prev_bs_ff   <= prev_bs_in;
         end
         cnt_ff <= cnt_in;
      end
      if (item_valid && item_ready) begin
         ko_at_ff <= ko_at_in;
         kc_at_ff <= kc_at_in;
         vo_at_ff <= vo_at_in;
      end
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
   end

endmodule

`default_nettype wire

// ===== design/json_object_member_scanner.sv =====
// ----------------------------------------------------------------------------
// json_object_member_scanner
// Scans one JSON object text a character at a time and reports member
// key/value offsets and a status for the document.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_ready   char_byte, is_final
//   rsp_     out        rsp_valid/rsp_ready   kind, offsets, status, last_of_run
//
// One character per cycle while rsp_ready stays high and the result buffer has
// room; a character that ends a member and the document makes two items.
// Each character passes the front register, the queue and the result buffer.
// The classify stage and a four-entry queue let input keep flowing while the
// scanner waits for room in its two-entry result buffer.
// Reset is synchronous and returns the scanner to the start of a document.
// ----------------------------------------------------------------------------
`default_nettype none

module json_object_member_scanner (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire jomsc_pkg::req_payload_type req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output jomsc_pkg::rsp_payload_type      rsp_payload
);

   logic                      f_valid;
   logic                      f_ready;
   jomsc_pkg::class_item_type f_item;
   logic                      q_valid;
   logic                      q_ready;
   jomsc_pkg::class_item_type q_item;

   jomsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .item_valid  (f_valid),
      .item_ready  (f_ready),
      .item        (f_item)
   );

   jomsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   jomsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (q_valid),
      .item_ready  (q_ready),
      .item        (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== bench/json_object_member_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// json_object_member_scanner_tb
// Feeds JSON object texts one character per item through the scanner and
// checks every member and status item against a cycle-free scanner model kept
// in the bench. Short directed documents come first, then random objects
// (mostly well formed, some damaged) and random noise. Sender idles in
// bursts, receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module json_object_member_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_CHARS = 900;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   jomsc_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   jomsc_pkg::rsp_payload_type rsp_payload;

   json_object_member_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- scanner model
   logic [15:0] char_pos;
   logic [7:0]  last_ch;
   logic [15:0] key_from, key_to, value_from;
   logic [15:0] brace_lvl, bracket_lvl;
   bit          in_str, value_pending, comma_seen, bad_first, seen_first;
   bit          key_from_ok, key_to_ok, value_from_ok;
   logic [2:0]  scan_err;

   jomsc_pkg::rsp_payload_type expected_q[$];
   jomsc_pkg::req_payload_type pending_q[$];
   logic [7:0]                 doc_buf[$];
   int                         chars_queued = 0;
   int                         error_count = 0;

   task automatic forget_member();
      key_from_ok   = 1'b0;
      key_to_ok     = 1'b0;
      value_from_ok = 1'b0;
      key_from      = '0;
      key_to        = '0;
      value_from    = '0;
      value_pending = 1'b0;
   endtask

   task automatic restart_document();
      char_pos    = '0;
      last_ch     = '0;
      forget_member();
      brace_lvl   = 16'd1;
      bracket_lvl = '0;
      in_str      = 1'b0;
      comma_seen  = 1'b0;
      bad_first   = 1'b0;
      scan_err    = jomsc_pkg::STATUS_OK;
      seen_first  = 1'b0;
   endtask

   function automatic jomsc_pkg::rsp_payload_type member_item(logic [15:0] stop_at);
      jomsc_pkg::rsp_payload_type r;
      r             = '0;
      r.kind        = jomsc_pkg::KIND_MEMBER;
      r.key_begin   = key_from;
      r.key_stop    = key_to;
      r.value_begin = value_from;
      r.value_stop  = stop_at;
      r.status      = jomsc_pkg::STATUS_OK;
      return r;
   endfunction

   task automatic predict_char(input logic [7:0] ch, input logic fin);
      jomsc_pkg::rsp_payload_type outs[2];
      int                         n;
      logic [15:0]                pos;
      logic [15:0]                gap;
      logic [2:0]                 st;
      bit                         guarded;
      bit                         blank;
      n       = 0;
      pos     = char_pos;
      guarded = bracket_lvl != 16'd0 || in_str || brace_lvl > 16'd1;
      blank   = ch == jomsc_pkg::ASCII_SPACE || ch == jomsc_pkg::ASCII_TAB ||
                ch == jomsc_pkg::ASCII_LF || ch == jomsc_pkg::ASCII_CR;
      if (!seen_first) begin
         seen_first = 1'b1;
         bad_first  = ch != jomsc_pkg::ASCII_LBRACE;
      end else if (!bad_first && scan_err == jomsc_pkg::STATUS_OK) begin
         case (ch)
            jomsc_pkg::ASCII_LBRACK: bracket_lvl = bracket_lvl + 16'd1;
            jomsc_pkg::ASCII_RBRACK: bracket_lvl = bracket_lvl - 16'd1;
            jomsc_pkg::ASCII_QUOTE: begin
               if (last_ch != jomsc_pkg::ASCII_BSLASH) begin
                  if (!key_from_ok) begin
                     key_from    = pos + 16'd1;
                     key_from_ok = 1'b1;
                     key_to_ok   = 1'b0;
                     key_to      = '0;
                     in_str      = 1'b1;
                  end else if (!key_to_ok) begin
                     key_to    = pos;
                     key_to_ok = 1'b1;
                     in_str    = 1'b0;
                  end else begin
                     in_str = !in_str;
                  end
               end
            end
            jomsc_pkg::ASCII_LBRACE: brace_lvl = brace_lvl + 16'd1;
            jomsc_pkg::ASCII_RBRACE: begin
               brace_lvl = brace_lvl - 16'd1;
               if (!guarded) begin
                  if (key_from_ok && key_to_ok && !value_from_ok) begin
                     scan_err = jomsc_pkg::STATUS_BAD_VALUE;
                  end else if (value_from_ok && value_from == pos) begin
                     scan_err = jomsc_pkg::STATUS_BAD_VALUE;
                  end else begin
                     if (key_from_ok && key_to_ok && value_from_ok) begin
                        outs[n] = member_item(pos);
                        n++;
                        forget_member();
                        comma_seen = 1'b0;
                     end
                     if (comma_seen)
                        scan_err = jomsc_pkg::STATUS_TRAIL_COMMA;
                  end
               end
            end
            jomsc_pkg::ASCII_COMMA: begin
               if (!guarded) begin
                  if (!value_from_ok) begin
                     scan_err = jomsc_pkg::STATUS_BAD_VALUE;
                  end else begin
                     if (key_from_ok && key_to_ok) begin
                        outs[n] = member_item(pos);
                        n++;
                        forget_member();
                     end
                     comma_seen = 1'b1;
                  end
               end
            end
            jomsc_pkg::ASCII_COLON: begin
               if (!guarded) begin
                  if (value_from_ok) begin
                     scan_err = jomsc_pkg::STATUS_BAD_OBJECT;
                  end else if (!(key_from_ok && key_to_ok)) begin
                     scan_err = jomsc_pkg::STATUS_BAD_KEY;
                  end else begin
                     value_from    = pos + 16'd1;
                     value_from_ok = 1'b1;
                     value_pending = 1'b1;
                  end
               end
            end
            default: begin
               if (!key_from_ok && !blank) begin
                  scan_err = jomsc_pkg::STATUS_BAD_KEY;
               end else if (key_from_ok && key_to_ok && !blank && !value_from_ok) begin
                  scan_err = jomsc_pkg::STATUS_BAD_OBJECT;
               end else if (value_from_ok && value_pending) begin
                  if (blank && !guarded) begin
                     // only blanks right at the value start move it forward
                     gap = pos - value_from;
                     if (gap <= 16'd1)
                        value_from = pos + 16'd1;
                  end else begin
                     value_pending = 1'b0;
                  end
               end
            end
         endcase
      end
      last_ch  = ch;
      char_pos = pos + 16'd1;
      if (fin) begin
         if (bad_first || ch != jomsc_pkg::ASCII_RBRACE)
            st = jomsc_pkg::STATUS_BAD_OBJECT;
         else if (scan_err != jomsc_pkg::STATUS_OK)
            st = scan_err;
         else if (bracket_lvl != 16'd0 || brace_lvl != 16'd0 || in_str)
            st = jomsc_pkg::STATUS_UNBALANCED;
         else
            st = jomsc_pkg::STATUS_OK;
         outs[n]        = '0;
         outs[n].kind   = jomsc_pkg::KIND_STATUS;
         outs[n].status = st;
         n++;
         restart_document();
      end
      if (n > 0)
         outs[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++)
         expected_q.push_back(outs[i]);
   endtask

   // ---------------------------------------------------------------- document builder
   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         doc_buf.push_back(s[i]);
   endtask

   task automatic put_blanks(input int most);
      int cnt;
      cnt = $urandom_range(0, most);
      repeat (cnt) begin
         case ($urandom_range(0, 3))
            0: doc_buf.push_back(jomsc_pkg::ASCII_SPACE);
            1: doc_buf.push_back(jomsc_pkg::ASCII_TAB);
            2: doc_buf.push_back(jomsc_pkg::ASCII_LF);
            default: doc_buf.push_back(jomsc_pkg::ASCII_CR);
         endcase
      end
   endtask

   task automatic put_string(input bit is_key);
      int cnt;
      int pick;
      cnt = is_key ? $urandom_range(0, 3) : $urandom_range(0, 6);
      doc_buf.push_back(jomsc_pkg::ASCII_QUOTE);
      repeat (cnt) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            doc_buf.push_back(jomsc_pkg::ASCII_BSLASH);
            doc_buf.push_back(jomsc_pkg::ASCII_QUOTE);
         end else if (!is_key && pick < 4) begin
            doc_buf.push_back(jomsc_pkg::ASCII_SPACE);
         end else if (!is_key && pick < 7) begin
            doc_buf.push_back(8'($urandom_range(128, 255)));
         end else begin
            doc_buf.push_back(8'($urandom_range(97, 122)));
         end
      end
      doc_buf.push_back(jomsc_pkg::ASCII_QUOTE);
   endtask

   task automatic put_member(input int lvl);
      put_blanks(2);
      put_string(1'b1);
      put_blanks(1);
      doc_buf.push_back(jomsc_pkg::ASCII_COLON);
      put_blanks(3);
      put_value(lvl);
      put_blanks(1);
   endtask

   task automatic put_value(input int lvl);
      int cnt;
      case ($urandom_range(0, lvl >= 2 ? 2 : 4))
         0: begin
            if ($urandom_range(0, 3) == 0)
               put_text("-");
            cnt = $urandom_range(1, 4);
            repeat (cnt) doc_buf.push_back(8'($urandom_range(48, 57)));
         end
         1: put_string(1'b0);
         2: begin
            case ($urandom_range(0, 2))
               0: put_text("true");
               1: put_text("false");
               default: put_text("null");
            endcase
         end
         3: begin
            doc_buf.push_back(jomsc_pkg::ASCII_LBRACK);
            cnt = $urandom_range(0, 3);
            for (int i = 0; i < cnt; i++) begin
               if (i > 0)
                  doc_buf.push_back(jomsc_pkg::ASCII_COMMA);
               put_blanks(1);
               put_value(lvl + 1);
            end
            doc_buf.push_back(jomsc_pkg::ASCII_RBRACK);
         end
         default: begin
            doc_buf.push_back(jomsc_pkg::ASCII_LBRACE);
            cnt = $urandom_range(0, 2);
            for (int i = 0; i < cnt; i++) begin
               if (i > 0)
                  doc_buf.push_back(jomsc_pkg::ASCII_COMMA);
               put_member(lvl + 1);
            end
            doc_buf.push_back(jomsc_pkg::ASCII_RBRACE);
         end
      endcase
   endtask

   function automatic logic [7:0] syntax_char();
      case ($urandom_range(0, 8))
         0: return jomsc_pkg::ASCII_LBRACE;
         1: return jomsc_pkg::ASCII_RBRACE;
         2: return jomsc_pkg::ASCII_LBRACK;
         3: return jomsc_pkg::ASCII_RBRACK;
         4: return jomsc_pkg::ASCII_QUOTE;
         5: return jomsc_pkg::ASCII_COMMA;
         6: return jomsc_pkg::ASCII_COLON;
         7: return jomsc_pkg::ASCII_BSLASH;
         default: return jomsc_pkg::ASCII_SPACE;
      endcase
   endfunction

   // damage a well-formed document in one spot
   task automatic damage_doc();
      int idx;
      idx = $urandom_range(0, doc_buf.size() - 1);
      case ($urandom_range(0, 3))
         0: doc_buf[idx] = 8'($urandom_range(0, 255));
         1: if (doc_buf.size() > 2) doc_buf.delete(idx);
         2: doc_buf.insert(doc_buf.size() - 1, jomsc_pkg::ASCII_COMMA);
         default: doc_buf.insert(idx, syntax_char());
      endcase
   endtask

   task automatic flush_doc();
      jomsc_pkg::req_payload_type item;
      for (int i = 0; i < doc_buf.size(); i++) begin
         item.char_byte = doc_buf[i];
         item.is_final  = i == doc_buf.size() - 1;
         pending_q.push_back(item);
         chars_queued++;
      end
      doc_buf.delete();
   endtask

   task automatic put_object();
      int cnt;
      doc_buf.push_back(jomsc_pkg::ASCII_LBRACE);
      cnt = $urandom_range(0, 3);
      for (int i = 0; i < cnt; i++) begin
         if (i > 0)
            doc_buf.push_back(jomsc_pkg::ASCII_COMMA);
         put_member(0);
      end
      doc_buf.push_back(jomsc_pkg::ASCII_RBRACE);
      if ($urandom_range(0, 3) == 0)
         damage_doc();
   endtask

   task automatic put_noise();
      int cnt;
      cnt = $urandom_range(1, 10);
      for (int i = 0; i < cnt; i++) begin
         if (i == 0 && $urandom_range(0, 4) < 3)
            doc_buf.push_back(jomsc_pkg::ASCII_LBRACE);
         else if ($urandom_range(0, 1) == 0)
            doc_buf.push_back(syntax_char());
         else
            doc_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("%0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------- driver
   bit req_taken = 1'b0;
   int burst_left = 1;
   int idle_gap = 0;
   int stall_tick = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (idle_gap > 0) begin
            idle_gap--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_payload <= pending_q.pop_front();
            req_valid   <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               idle_gap   = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end

      // receiver pattern: free running, coin flip, one in three, stall runs
      stall_tick++;
      case ((stall_tick / 97) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= stall_tick % 3 == 0;
         default: rsp_ready <= stall_tick % 11 >= 5;
      endcase
   end

   // ---------------------------------------------------------------- monitor
   jomsc_pkg::rsp_payload_type wanted;
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken)
            predict_char(req_payload.char_byte, req_payload.is_final);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("item with none expected: kind %0d status %0d",
                                         rsp_payload.kind, rsp_payload.status));
            end else begin
               wanted = expected_q.pop_front();
               if (rsp_payload.kind !== wanted.kind)
                  report_mismatch($sformatf("kind %0h, expected %0h",
                                            rsp_payload.kind, wanted.kind));
               if (rsp_payload.key_begin !== wanted.key_begin)
                  report_mismatch($sformatf("key_begin %0h, expected %0h",
                                            rsp_payload.key_begin, wanted.key_begin));
               if (rsp_payload.key_stop !== wanted.key_stop)
                  report_mismatch($sformatf("key_stop %0h, expected %0h",
                                            rsp_payload.key_stop, wanted.key_stop));
               if (rsp_payload.value_begin !== wanted.value_begin)
                  report_mismatch($sformatf("value_begin %0h, expected %0h",
                                            rsp_payload.value_begin, wanted.value_begin));
               if (rsp_payload.value_stop !== wanted.value_stop)
                  report_mismatch($sformatf("value_stop %0h, expected %0h",
                                            rsp_payload.value_stop, wanted.value_stop));
               if (rsp_payload.status !== wanted.status)
                  report_mismatch($sformatf("status %0h, expected %0h",
                                            rsp_payload.status, wanted.status));
               if (rsp_payload.last_of_run !== wanted.last_of_run)
                  report_mismatch($sformatf("last_of_run %0h, expected %0h",
                                            rsp_payload.last_of_run, wanted.last_of_run));
            end
         end
         if (req_taken || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("json_object_member_scanner_tb: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus and end
   initial begin
      restart_document();

      // one-character document, bad first character
      put_text("}");
      flush_doc();
      // escaped quote in key, blank before value, member and status on last brace
      put_text("{\"a\\\"\": 1}");
      flush_doc();
      // bracket depth wraps below zero
      put_text("{]]}");
      flush_doc();
      put_text("{\"k\":1,}");
      flush_doc();
      // extreme byte values outside a key
      doc_buf.push_back(jomsc_pkg::ASCII_LBRACE);
      doc_buf.push_back(8'h00);
      doc_buf.push_back(8'hFF);
      doc_buf.push_back(jomsc_pkg::ASCII_RBRACE);
      flush_doc();

      while (chars_queued < RANDOM_CHARS + 27) begin
         if ($urandom_range(0, 9) == 0) begin
            put_noise();
            flush_doc();
         end else begin
            put_object();
            flush_doc();
         end
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      if (error_count == 0 && expected_q.size() == 0)
         $display("json_object_member_scanner_tb: clean");
      else
         $display("json_object_member_scanner_tb: errors");
      $finish;
   end

endmodule

// ===== json_object_member_scanner.f =====
design/jomsc_pkg.sv
design/jomsc_front.sv
design/jomsc_queue.sv
design/jomsc_back.sv
design/json_object_member_scanner.sv
bench/json_object_member_scanner_tb.sv
